FILE: rtl/hsl_pkg.sv
// ----------------------------------------------------------------------------
// hsl_pkg
// Shared constants and codes for the hsl to rgb pixel converter.
// ----------------------------------------------------------------------------
package hsl_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int S_DATA_W        = 72;
    localparam int M_DATA_W        = 64;

    // packing and scale of the result word
    typedef enum logic [1:0] {
        LAYOUT_BGRA8  = 2'd0,
        LAYOUT_ARGB8  = 2'd1,
        LAYOUT_BGRA16 = 2'd2,
        LAYOUT_ARGB16 = 2'd3
    } layout_t;

    // which part of the hue curve a channel falls on
    typedef enum logic [1:0] {
        SEG_RISE = 2'd0,
        SEG_TOP  = 2'd1,
        SEG_FALL = 2'd2,
        SEG_BASE = 2'd3
    } segment_t;

endpackage

FILE: rtl/hsl_to_rgb_pixel_converter.sv
// ----------------------------------------------------------------------------
// hsl_to_rgb_pixel_converter
// Streaming hsl to rgb converter with selectable output packing.
// ----------------------------------------------------------------------------
// usage:
//   pixels enter on the s_ stream: one word carries hue, saturation,
//   lightness and alpha, s_tlast marks the last pixel of a frame.
//   results leave on the m_ stream as two packed 32-bit words, m_tlast
//   copies the frame marker.
//   cfg_valid/cfg_data select the layout (bgra/argb, 8 or 16 bit); write
//   it only while no pixel is in flight. cfg_ready is always high.
// timing:
//   one pixel per clock while m_tready stays high; an accepted pixel passes
//   the front input register, a queue slot, then five back stages ending in
//   the output register. the back multipliers set the stage count.
// reset and stalls:
//   aresetn clears all valid flags, the queue and the layout (bgra 8-bit).
//   a stalled m_tready holds the result; s_tready drops only once the
//   back stages, the queue and the front input register are all full.
// ----------------------------------------------------------------------------
module hsl_to_rgb_pixel_converter
    import hsl_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // hue[15:0], saturation[32:16], lightness[49:33], alpha[65:50], zero pad
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    // word_low[31:0], word_high[63:32]
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_data
);

    localparam int ENTRY_W = 5 * FRAC_BITS + 30;

    layout_t            layout_reg;
    logic               fq_valid, fq_ready, qb_valid, qb_ready;
    logic [ENTRY_W-1:0] fq_data, qb_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            layout_reg <= LAYOUT_BGRA8;
        end else if (cfg_valid && cfg_ready) begin
            layout_reg <= layout_t'(cfg_data);
        end
    end

    hsl_front #(
        .FRAC_BITS (FRAC_BITS),
        .ENTRY_W   (ENTRY_W)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_data   (fq_data)
    );

    hsl_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_data)
    );

    hsl_back #(
        .FRAC_BITS (FRAC_BITS),
        .ENTRY_W   (ENTRY_W)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (qb_valid),
        .q_ready  (qb_ready),
        .q_data   (qb_data),
        .layout   (layout_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: rtl/hsl_front.sv
// ----------------------------------------------------------------------------
// hsl_front
// Takes pixels in, converts to internal fixed point and classifies each
// channel's hue position, producing one queue entry per pixel.
// ----------------------------------------------------------------------------
module hsl_front
    import hsl_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int ENTRY_W   = 5 * FRAC_BITS + 30
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // hue[15:0], saturation[32:16], lightness[49:33], alpha[65:50], zero pad
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tlast,
    output logic                q_valid,
    input  logic                q_ready,
    output logic [ENTRY_W-1:0]  q_data
);

    localparam int VW  = FRAC_BITS + 1;
    localparam int SHL = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int SHR = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam logic [VW-1:0] ONE   = VW'(64'd1 << FRAC_BITS);
    localparam logic [VW-1:0] THIRD = VW'((64'd1 << FRAC_BITS) / 3);
    localparam logic [VW+2:0] K1    = (VW+3)'(64'd1 << FRAC_BITS);
    localparam logic [VW+2:0] K3    = (VW+3)'((64'd3) << FRAC_BITS);
    localparam logic [VW+2:0] K4    = (VW+3)'((64'd4) << FRAC_BITS);
    localparam logic [16:0]   FULL  = 17'd65536;

    logic        valid_reg;
    logic [15:0] hue_reg;
    logic [16:0] sat_reg;
    logic [16:0] light_reg;
    logic [15:0] alpha_reg;
    logic        last_reg;

    logic [16:0]   sat_c, light_c;
    logic [VW-1:0] h, s, l, tr, tb;
    logic [VW:0]   tr_sum;
    logic          grey, low;
    segment_t      seg_r, seg_g, seg_b;
    logic [VW-1:0] m_r, m_g, m_b;

    function automatic logic [VW-1:0] to_fixed(input logic [16:0] x);
        logic [FRAC_BITS+16:0] t;
        t = {{FRAC_BITS{1'b0}}, x} << SHL;
        return VW'(t >> SHR);
    endfunction

    function automatic void classify(input logic [VW-1:0] t,
                                     output segment_t sg, output logic [VW-1:0] m);
        logic [VW+2:0] t6;
        t6 = ({3'b000, t} << 2) + ({3'b000, t} << 1);
        if (t6 < K1) begin
            sg = SEG_RISE;
            m  = VW'(t6);
        end else if (t6 < K3) begin
            sg = SEG_TOP;
            m  = '0;
        end else if (t6 < K4) begin
            sg = SEG_FALL;
            m  = VW'(K4 - t6);
        end else begin
            sg = SEG_BASE;
            m  = '0;
        end
    endfunction

    assign s_tready = !valid_reg || q_ready;
    assign q_valid  = valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            hue_reg   <= s_tdata[15:0];
            sat_reg   <= s_tdata[32:16];
            light_reg <= s_tdata[49:33];
            alpha_reg <= s_tdata[65:50];
            last_reg  <= s_tlast;
        end
    end

    always_comb begin
        sat_c   = (sat_reg > FULL) ? FULL : sat_reg;
        light_c = (light_reg > FULL) ? FULL : light_reg;
        h = to_fixed({1'b0, hue_reg});
        s = to_fixed(sat_c);
        l = to_fixed(light_c);
        grey = (s == '0);
        low  = (l < (ONE >> 1));
        // red is a third ahead, blue a third behind, both wrapped
        tr_sum = {1'b0, h} + {1'b0, THIRD};
        tr = (tr_sum > {1'b0, ONE}) ? VW'(tr_sum - {1'b0, ONE}) : VW'(tr_sum);
        tb = (h >= THIRD) ? (h - THIRD) : (h + ONE - THIRD);
        classify(tr, seg_r, m_r);
        classify(h, seg_g, m_g);
        classify(tb, seg_b, m_b);
    end

    assign q_data = {last_reg, alpha_reg, m_b, m_g, m_r,
                     seg_b, seg_g, seg_r, low, grey, s, l};

endmodule

FILE: rtl/hsl_queue.sv
// ----------------------------------------------------------------------------
// hsl_queue
// Small first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module hsl_queue
    import hsl_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             push, pop;

    assign wr_ready = (count_reg != CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: rtl/hsl_back.sv
// ----------------------------------------------------------------------------
// hsl_back
// Forms the helper levels, evaluates each channel, scales, clamps and packs
// the result word, in a stallable pipeline ending in the output register.
// ----------------------------------------------------------------------------
module hsl_back
    import hsl_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int ENTRY_W   = 5 * FRAC_BITS + 30
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  logic [ENTRY_W-1:0]  q_data,
    input  layout_t             layout,
    output logic                m_tvalid,
    input  logic                m_tready,
    // word_low[31:0], word_high[63:32]
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast
);

    localparam int VW = FRAC_BITS + 1;
    localparam logic [VW-1:0] ONE = VW'(64'd1 << FRAC_BITS);

    // queue entry fields
    logic [VW-1:0] e_l, e_s, e_m_r, e_m_g, e_m_b;
    logic          e_grey, e_low, e_last;
    logic [1:0]    e_seg_r, e_seg_g, e_seg_b;
    logic [15:0]   e_alpha;

    assign {e_last, e_alpha, e_m_b, e_m_g, e_m_r,
            e_seg_b, e_seg_g, e_seg_r, e_low, e_grey, e_s, e_l} = q_data;

    logic v1_reg, v2_reg, v3_reg, v4_reg, vo_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdyo;

    assign rdyo    = !vo_reg || m_tready;
    assign rdy4    = !v4_reg || rdyo;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign q_ready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= q_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdyo) vo_reg <= v4_reg;
        end
    end

    // stage 1: product for the upper helper level
    logic [VW:0]     mb;
    logic [2*VW:0]   prod1_reg;
    logic [VW-1:0]   l1_reg, s1_reg, m_r1_reg, m_g1_reg, m_b1_reg;
    logic            grey1_reg, low1_reg, last1_reg;
    segment_t        seg_r1_reg, seg_g1_reg, seg_b1_reg;
    logic [15:0]     alpha1_reg;

    assign mb = e_low ? ({1'b0, ONE} + {1'b0, e_s}) : {1'b0, e_s};

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            prod1_reg  <= {{(VW+1){1'b0}}, e_l} * {{VW{1'b0}}, mb};
            l1_reg     <= e_l;
            s1_reg     <= e_s;
            grey1_reg  <= e_grey;
            low1_reg   <= e_low;
            seg_r1_reg <= segment_t'(e_seg_r);
            seg_g1_reg <= segment_t'(e_seg_g);
            seg_b1_reg <= segment_t'(e_seg_b);
            m_r1_reg   <= e_m_r;
            m_g1_reg   <= e_m_g;
            m_b1_reg   <= e_m_b;
            alpha1_reg <= e_alpha;
            last1_reg  <= e_last;
        end
    end

    // stage 2: helper levels q, p and their span
    logic [VW:0]   qs, q_wide;
    logic [VW-1:0] q_c, p_c;
    logic [VW-1:0] q2_reg, p2_reg, d2_reg, l2_reg, m_r2_reg, m_g2_reg, m_b2_reg;
    logic          grey2_reg, last2_reg;
    segment_t      seg_r2_reg, seg_g2_reg, seg_b2_reg;
    logic [15:0]   alpha2_reg;

    always_comb begin
        qs     = (VW+1)'(prod1_reg >> FRAC_BITS);
        q_wide = low1_reg ? qs : ({1'b0, l1_reg} + {1'b0, s1_reg} - qs);
        q_c    = VW'(q_wide);
        p_c    = VW'({l1_reg, 1'b0} - {1'b0, q_c});
    end

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            q2_reg     <= q_c;
            p2_reg     <= p_c;
            d2_reg     <= q_c - p_c;
            l2_reg     <= l1_reg;
            grey2_reg  <= grey1_reg;
            seg_r2_reg <= seg_r1_reg;
            seg_g2_reg <= seg_g1_reg;
            seg_b2_reg <= seg_b1_reg;
            m_r2_reg   <= m_r1_reg;
            m_g2_reg   <= m_g1_reg;
            m_b2_reg   <= m_b1_reg;
            alpha2_reg <= alpha1_reg;
            last2_reg  <= last1_reg;
        end
    end

    // stage 3: ramp products, one per channel
    logic [2*VW-1:0] pr_r3_reg, pr_g3_reg, pr_b3_reg;
    logic [VW-1:0]   q3_reg, p3_reg, l3_reg;
    logic            grey3_reg, last3_reg;
    segment_t        seg_r3_reg, seg_g3_reg, seg_b3_reg;
    logic [15:0]     alpha3_reg;

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            pr_r3_reg  <= {{VW{1'b0}}, d2_reg} * {{VW{1'b0}}, m_r2_reg};
            pr_g3_reg  <= {{VW{1'b0}}, d2_reg} * {{VW{1'b0}}, m_g2_reg};
            pr_b3_reg  <= {{VW{1'b0}}, d2_reg} * {{VW{1'b0}}, m_b2_reg};
            q3_reg     <= q2_reg;
            p3_reg     <= p2_reg;
            l3_reg     <= l2_reg;
            grey3_reg  <= grey2_reg;
            seg_r3_reg <= seg_r2_reg;
            seg_g3_reg <= seg_g2_reg;
            seg_b3_reg <= seg_b2_reg;
            alpha3_reg <= alpha2_reg;
            last3_reg  <= last2_reg;
        end
    end

    // stage 4: channel levels
    function automatic logic [VW-1:0] level(input segment_t sg, input logic [2*VW-1:0] pr,
                                            input logic [VW-1:0] q, input logic [VW-1:0] p);
        logic [VW-1:0] ramp;
        ramp = p + VW'(pr >> FRAC_BITS);
        case (sg)
            SEG_RISE: return ramp;
            SEG_TOP:  return q;
            SEG_FALL: return ramp;
            default:  return p;
        endcase
    endfunction

    logic [VW-1:0] vr4_reg, vg4_reg, vb4_reg;
    logic [15:0]   alpha4_reg;
    logic          last4_reg;

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            vr4_reg    <= grey3_reg ? l3_reg : level(seg_r3_reg, pr_r3_reg, q3_reg, p3_reg);
            vg4_reg    <= grey3_reg ? l3_reg : level(seg_g3_reg, pr_g3_reg, q3_reg, p3_reg);
            vb4_reg    <= grey3_reg ? l3_reg : level(seg_b3_reg, pr_b3_reg, q3_reg, p3_reg);
            alpha4_reg <= alpha3_reg;
            last4_reg  <= last3_reg;
        end
    end

    // stage 5: scale, clamp and pack into the output register
    function automatic logic [15:0] to_code(input logic [VW-1:0] v, input logic wide);
        logic [VW+8:0]  s8;
        logic [VW+8:0]  c8;
        logic [VW+14:0] c16;
        s8  = ({9'd0, v} << 8) - {9'd0, v};
        c8  = s8 >> FRAC_BITS;
        c16 = ({15'd0, v} << 15) >> FRAC_BITS;
        if (wide) begin
            return (c16 > (VW+15)'(32768)) ? 16'd32768 : 16'(c16);
        end
        return (c8 > (VW+9)'(255)) ? 16'd255 : 16'(c8);
    endfunction

    logic        wide;
    logic [15:0] r, g, b;
    logic [7:0]  a8;
    logic [31:0] lo, hi;
    logic [M_DATA_W-1:0] tdata_reg;
    logic        tlast_reg;

    always_comb begin
        wide = (layout == LAYOUT_BGRA16) || (layout == LAYOUT_ARGB16);
        r  = to_code(vr4_reg, wide);
        g  = to_code(vg4_reg, wide);
        b  = to_code(vb4_reg, wide);
        a8 = alpha4_reg[7:0];
        case (layout)
            LAYOUT_BGRA8: begin
                lo = {a8, r[7:0], g[7:0], b[7:0]};
                hi = '0;
            end
            LAYOUT_ARGB8: begin
                lo = {b[7:0], g[7:0], r[7:0], a8};
                hi = '0;
            end
            LAYOUT_BGRA16: begin
                lo = {g, b};
                hi = {alpha4_reg, r};
            end
            default: begin
                lo = {r, alpha4_reg};
                hi = {b, g};
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rdyo) begin
            tdata_reg <= {hi, lo};
            tlast_reg <= last4_reg;
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = tdata_reg;
    assign m_tlast  = tlast_reg;

endmodule

FILE: dv/hsl_pixel_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hsl_pixel_checker
// Watches the pixel, result and layout channels of the hsl to rgb converter,
// works out the packed rgb word for every accepted pixel and compares each
// result word against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module hsl_pixel_checker
    import hsl_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tlast,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,
    input  logic                m_tlast,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [1:0]          cfg_data,
    output int                  mismatches,
    output int                  pixels_in_flight
);

    localparam int     FB    = FRAC_BITS_DEF;
    localparam longint UNIT  = longint'(1) << FB;
    localparam longint THIRD = UNIT / 3;

    typedef struct packed {
        logic [31:0] word_low;
        logic [31:0] word_high;
        logic        frame_last;
    } rgb_pixel_t;

    rgb_pixel_t expected_pixels[$];
    rgb_pixel_t got_px;
    rgb_pixel_t want_px;
    layout_t    active_layout = LAYOUT_BGRA8;

    function automatic longint q16_to_fixed(longint x);
        if (FB >= 16) begin
            return x <<< (FB - 16);
        end
        return x >>> (16 - FB);
    endfunction

    // piecewise hue curve between the low and high helper levels
    function automatic longint hue_curve(longint lo_lvl, longint hi_lvl, longint t);
        longint   span;
        segment_t seg;
        span = hi_lvl - lo_lvl;
        if (6 * t < UNIT) begin
            seg = SEG_RISE;
        end else if (2 * t < UNIT) begin
            seg = SEG_TOP;
        end else if (3 * t < 2 * UNIT) begin
            seg = SEG_FALL;
        end else begin
            seg = SEG_BASE;
        end
        case (seg)
            SEG_RISE: return lo_lvl + ((span * (6 * t)) >>> FB);
            SEG_TOP:  return hi_lvl;
            SEG_FALL: return lo_lvl + ((span * (4 * UNIT - 6 * t)) >>> FB);
            default:  return lo_lvl;
        endcase
    endfunction

    function automatic logic [15:0] level_to_code(longint level, bit wide);
        longint scale;
        longint code;
        scale = wide ? 32768 : 255;
        if (level < 0) begin
            level = 0;
        end
        code = (level * scale) >>> FB;
        if (code > scale) begin
            code = scale;
        end
        return code[15:0];
    endfunction

    function automatic rgb_pixel_t hsl_to_packed_rgb(logic [15:0] hue, logic [16:0] sat_in,
                                                     logic [16:0] light_in, logic [15:0] alpha,
                                                     logic eof, layout_t lay);
        longint      h, s, l;
        longint      hi_lvl, lo_lvl, t_red, t_blue;
        longint      v_r, v_g, v_b;
        logic [16:0] sat_c, light_c;
        logic [15:0] r, g, b;
        rgb_pixel_t  px;
        sat_c   = (sat_in > 17'h10000) ? 17'h10000 : sat_in;
        light_c = (light_in > 17'h10000) ? 17'h10000 : light_in;
        h = q16_to_fixed(longint'(hue));
        s = q16_to_fixed(longint'(sat_c));
        l = q16_to_fixed(longint'(light_c));
        if (s == 0) begin
            v_r = l;
            v_g = l;
            v_b = l;
        end else begin
            if (2 * l < UNIT) begin
                hi_lvl = (l * (UNIT + s)) >>> FB;
            end else begin
                hi_lvl = l + s - ((l * s) >>> FB);
            end
            lo_lvl = 2 * l - hi_lvl;
            t_red = h + THIRD;
            if (t_red > UNIT) begin
                t_red = t_red - UNIT;
            end
            t_blue = h - THIRD;
            if (t_blue < 0) begin
                t_blue = t_blue + UNIT;
            end
            v_r = hue_curve(lo_lvl, hi_lvl, t_red);
            v_g = hue_curve(lo_lvl, hi_lvl, h);
            v_b = hue_curve(lo_lvl, hi_lvl, t_blue);
        end
        r = level_to_code(v_r, lay[1]);
        g = level_to_code(v_g, lay[1]);
        b = level_to_code(v_b, lay[1]);
        px.word_high  = '0;
        px.frame_last = eof;
        case (lay)
            LAYOUT_BGRA8: px.word_low = {alpha[7:0], r[7:0], g[7:0], b[7:0]};
            LAYOUT_ARGB8: px.word_low = {b[7:0], g[7:0], r[7:0], alpha[7:0]};
            LAYOUT_BGRA16: begin
                px.word_low  = {g, b};
                px.word_high = {alpha, r};
            end
            default: begin
                px.word_low  = {r, alpha};
                px.word_high = {b, g};
            end
        endcase
        return px;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_pixels.delete();
            active_layout = LAYOUT_BGRA8;
            pixels_in_flight <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_px = {m_tdata[31:0], m_tdata[63:32], m_tlast};
                if (expected_pixels.size() == 0) begin
                    $error("result word with no pixel outstanding: tdata %h", m_tdata);
                    mismatches++;
                end else begin
                    want_px = expected_pixels.pop_front();
                    if (got_px.word_low !== want_px.word_low) begin
                        $error("word_low: expected %h, got %h", want_px.word_low,
                               got_px.word_low);
                        mismatches++;
                    end
                    if (got_px.word_high !== want_px.word_high) begin
                        $error("word_high: expected %h, got %h", want_px.word_high,
                               got_px.word_high);
                        mismatches++;
                    end
                    if (got_px.frame_last !== want_px.frame_last) begin
                        $error("frame_last: expected %b, got %b", want_px.frame_last,
                               got_px.frame_last);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_pixels.push_back(hsl_to_packed_rgb(s_tdata[15:0], s_tdata[32:16],
                                                            s_tdata[49:33], s_tdata[65:50],
                                                            s_tlast, active_layout));
            end
            if (cfg_valid && cfg_ready) begin
                active_layout = layout_t'(cfg_data);
            end
            pixels_in_flight <= expected_pixels.size();
        end
    end

endmodule

FILE: dv/tb_hsl_to_rgb_pixel_converter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hsl_to_rgb_pixel_converter
// Drives directed corner pixels and then bursts of random pixels through the
// converter under every output layout, with random source gaps and result
// back-pressure; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_hsl_to_rgb_pixel_converter
    import hsl_pkg::*;
();

    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int PIXELS_PER_PH = 80;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic                s_tlast   = 1'b0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [1:0]          cfg_data  = '0;

    int       mismatches;
    int       pixels_in_flight;
    int       burst_left = 0;
    int       idle_cycles = 0;
    int       rx_cycle = 0;
    int       rx_mode = 0;
    logic [15:0] rx_pattern = 16'hFFFF;
    layout_t  phase_layouts[8] = '{LAYOUT_ARGB16, LAYOUT_ARGB8, LAYOUT_BGRA16, LAYOUT_BGRA8,
                                   LAYOUT_ARGB16, LAYOUT_BGRA16, LAYOUT_ARGB8, LAYOUT_BGRA8};
    logic [15:0] hue_edges[8] = '{16'd0, 16'd10922, 16'd10923, 16'd21845,
                                  16'd32768, 16'd43690, 16'd43691, 16'hFFFF};

    hsl_to_rgb_pixel_converter u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    hsl_pixel_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tlast          (s_tlast),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tlast          (m_tlast),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .mismatches       (mismatches),
        .pixels_in_flight (pixels_in_flight)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // result side stalls, switching between a handful of behaviours
    always @(posedge aclk) begin
        rx_cycle++;
        if (rx_cycle % 50 == 0) begin
            rx_mode    = $urandom_range(0, 3);
            rx_pattern = 16'($urandom());
        end
        rx_pattern = {rx_pattern[14:0], rx_pattern[15]};
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= rx_pattern[0];
            default: m_tready <= (rx_cycle % 8 == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // wait until every accepted pixel has come back out
    task automatic wait_drained();
        do @(posedge aclk); while (pixels_in_flight != 0);
    endtask

    task automatic write_layout(layout_t lay);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= lay;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(logic [15:0] hue, logic [16:0] sat, logic [16:0] light,
                              logic [15:0] alpha, logic eof);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W - 66){1'b0}}, alpha, light, sat, hue};
        s_tlast  <= eof;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_random_pixel();
        logic [15:0] hue;
        logic [16:0] sat, light;
        if ($urandom_range(0, 7) == 0) begin
            hue = hue_edges[3'($urandom_range(0, 7))] + 16'($urandom_range(0, 2)) - 16'd1;
        end else begin
            hue = 16'($urandom_range(0, 65535));
        end
        case ($urandom_range(0, 9))
            0:       sat = 17'd0;
            1:       sat = 17'h10000;
            2:       sat = 17'($urandom_range(65537, 131071));
            default: sat = 17'($urandom_range(1, 65535));
        endcase
        case ($urandom_range(0, 9))
            0:       light = 17'd0;
            1:       light = 17'h10000;
            2:       light = 17'($urandom_range(65537, 131071));
            3:       light = 17'($urandom_range(32760, 32776));
            default: light = 17'($urandom_range(0, 65535));
        endcase
        send_pixel(hue, sat, light, 16'($urandom_range(0, 65535)), $urandom_range(0, 7) == 0);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        write_layout(LAYOUT_BGRA8);
        send_pixel(16'd0, 17'd0, 17'd0, 16'h0000, 1'b0);
        send_pixel(16'hFFFF, 17'h10000, 17'h10000, 16'hFFFF, 1'b1);
        // grey: no saturation
        send_pixel(16'h1234, 17'd0, 17'h08000, 16'h00FF, 1'b0);
        send_pixel(16'hABCD, 17'd0, 17'h10000, 16'hFF00, 1'b0);
        // saturation and lightness beyond full scale
        send_pixel(16'd0, 17'h1FFFF, 17'h08000, 16'h5A5A, 1'b0);
        send_pixel(16'h4000, 17'h0C000, 17'h1FFFF, 16'hA5A5, 1'b0);
        // red hue lands exactly on a full turn
        send_pixel(16'd43691, 17'h10000, 17'h08000, 16'h1234, 1'b0);
        // blue hue around the wrap at zero
        send_pixel(16'd21845, 17'h10000, 17'h08000, 16'h8001, 1'b0);
        send_pixel(16'd21844, 17'h10000, 17'h08000, 16'h7FFE, 1'b1);
        // either side of the sixth, half and two-thirds thresholds
        send_pixel(16'd10922, 17'h10000, 17'h08000, 16'h0001, 1'b0);
        send_pixel(16'd10923, 17'h10000, 17'h08000, 16'h0002, 1'b0);
        send_pixel(16'd32767, 17'h10000, 17'h08000, 16'h0004, 1'b0);
        send_pixel(16'd32768, 17'h10000, 17'h08000, 16'h0008, 1'b0);
        send_pixel(16'd43690, 17'h10000, 17'h08000, 16'h0010, 1'b0);
        // lightness just under half takes the other helper level formula
        send_pixel(16'hFFFF, 17'h10000, 17'h07FFF, 16'h0020, 1'b0);
        send_pixel(16'h2000, 17'h0C000, 17'h08000, 16'h0040, 1'b0);
        send_pixel(16'h8000, 17'd1, 17'd1, 16'h0080, 1'b0);
        send_pixel(16'h1555, 17'h0FFFF, 17'h0FFFF, 16'hFFFF, 1'b1);
        send_pixel(16'h5555, 17'h10000, 17'd1, 16'hC3C3, 1'b0);
        s_tvalid <= 1'b0;

        for (int ph = 0; ph < 8; ph++) begin
            write_layout(phase_layouts[3'(ph)]);
            for (int n = 0; n < PIXELS_PER_PH; n++) begin
                // hold the source off once until the pipe is empty
                if (ph == 2 && n == PIXELS_PER_PH / 2) begin
                    s_tvalid <= 1'b0;
                    wait_drained();
                end
                send_random_pixel();
            end
            s_tvalid <= 1'b0;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pixels_in_flight == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/hsl_pkg.sv
rtl/hsl_front.sv
rtl/hsl_queue.sv
rtl/hsl_back.sv
rtl/hsl_to_rgb_pixel_converter.sv
dv/hsl_pixel_checker.sv
dv/tb_hsl_to_rgb_pixel_converter.sv
